### src/pyro_fire_retry_sequencer_core_defines.svh
// Assertion macros for the pyro fire retry sequencer.
`ifndef PYRO_FIRE_RETRY_SEQUENCER_CORE_DEFINES_SVH
`define PYRO_FIRE_RETRY_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PFRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PFRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pfrs_pkg.sv
// Shared constants and codes for the pyro fire retry sequencer.
`default_nettype none

package pfrs_pkg;

  localparam int unsigned NUM_CH_DEF  = 1;
  localparam int unsigned PIN_FULL_MV = 3300;
  localparam int unsigned ADC_FULL    = 4095;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_ADDR_W  = 5;

  typedef enum logic [1:0] {
    ACT_POLL   = 2'd0,
    ACT_FIRE   = 2'd1,
    ACT_BACKUP = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CHANNEL = 2'd1,
    ST_NOT_ALLOWED = 2'd2,
    ST_BUSY        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_CONT_THRESH   = 3'd0,
    REG_PULSE         = 3'd1,
    REG_SETTLE        = 3'd2,
    REG_SAMPLE_PERIOD = 3'd3,
    REG_RETRY_LIMIT   = 3'd4,
    REG_DIVIDER       = 3'd5
  } reg_idx_t;

  localparam logic [11:0] RST_CONT_THRESH   = 12'd500;
  localparam logic [15:0] RST_PULSE         = 16'd1000;
  localparam logic [15:0] RST_SETTLE        = 16'd200;
  localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd100;
  localparam logic [3:0]  RST_RETRY_LIMIT   = 4'd1;
  localparam logic [3:0]  RST_DIVIDER       = 4'd11;

endpackage

`default_nettype wire

### src/pyro_fire_retry_sequencer_core.sv
// Pyro fire retry sequencer: ADC continuity sensing, fire pulse, settle and retry.
// An accepted in_ word passes the input register, then the result register, to out_.
// One word per cycle unless out_ stalls; the input and result registers part the sides.
// The scale multiply sits before the input register, divide and sequencing after it.
// Reset (rst_n low, synchronous) clears the sequencer and loads register defaults.
`default_nettype none

`include "pyro_fire_retry_sequencer_core_defines.svh"

module pyro_fire_retry_sequencer_core
  import pfrs_pkg::*;
#(
  parameter int unsigned NUM_CH = NUM_CH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: now_ms[31:0], channel[34:32], adc_raw[46:35], adc_ok[47], armed[48],
  //           ground_idle[49], init_phase[50], pad_test[51], zero[55:52]
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: action[1:0]
  input  wire logic [1:0]             in_tuser,
  // out_tdata: gate_on[0], gate_channel[3:1], phase[5:4], cont_out[13:6],
  //            fired_out[21:14], deploy_fail_flag[22], pin_mv_out[34:23],
  //            battery_mv[50:35], zero[55:51]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]                  out_tuser,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [31:0]            cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRING = 2'd1,
    PH_SETTLE = 2'd2
  } phase_t;

  localparam logic [3:0] NumChW = 4'(NUM_CH);

  // configuration registers
  logic [11:0] thresh_r;
  logic [15:0] pulse_r, settle_r, period_r;
  logic [3:0]  retry_lim_r, div_r;

  // input register
  logic        in_vld_r;
  logic [1:0]  act_r;
  logic [31:0] now_r;
  logic [2:0]  ch_r;
  logic [23:0] prod_r;
  logic        adc_ok_r, armed_r, gidle_r, init_r, test_r;

  // sequencer state
  phase_t            phase_r, phase_nxt;
  logic [2:0]        fire_ch_r, fire_ch_nxt;
  logic [31:0]       start_r, start_nxt;
  logic [3:0]        retry_r, retry_nxt;
  logic              backup_r, backup_nxt;
  logic [11:0]       pin_r, pin_nxt;
  logic              cont_r, cont_nxt;
  logic [NUM_CH-1:0] fired_r, fired_nxt;
  logic              deploy_r, deploy_nxt;
  logic [31:0]       last_r, last_nxt;

  // result register
  logic        out_vld_r;
  status_t     out_status_r, status_nxt;
  logic [2:0]  out_ch_r;
  phase_t      out_phase_r;
  logic        out_cont_r;
  logic [7:0]  out_fired_r;
  logic        out_deploy_r;
  logic [11:0] out_pin_r;

  logic        adv;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [23:0] prod_in;
  logic [11:0] quot;
  logic [12:0] rem;
  logic [11:0] pin_calc;
  logic        may_fire, aborting, cont_here;
  logic [31:0] since_sample, since_phase;
  logic [7:0]  ch_onehot;
  logic [15:0] battery;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign prod_in   = 24'(in_tdata[46:35]) * 24'(PIN_FULL_MV);

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_comb begin
    case (reg_idx_t'(cfg_idx))
      REG_CONT_THRESH:   cfg_prdata = 32'(thresh_r);
      REG_PULSE:         cfg_prdata = 32'(pulse_r);
      REG_SETTLE:        cfg_prdata = 32'(settle_r);
      REG_SAMPLE_PERIOD: cfg_prdata = 32'(period_r);
      REG_RETRY_LIMIT:   cfg_prdata = 32'(retry_lim_r);
      REG_DIVIDER:       cfg_prdata = 32'(div_r);
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // floor(prod / 4095): prod = q*4096 + low, so remainder is low + q, below twice 4095
  assign quot     = prod_r[23:12];
  assign rem      = {1'b0, prod_r[11:0]} + {1'b0, quot};
  assign pin_calc = (rem >= 13'(ADC_FULL)) ? quot + 12'd1 : quot;

  assign may_fire     = armed_r || (gidle_r && test_r);
  assign aborting     = !backup_r && !may_fire && (gidle_r || init_r);
  assign since_sample = now_r - last_r;
  assign since_phase  = now_r - start_r;
  assign ch_onehot    = 8'd1 << ch_r;

  always_comb begin
    phase_nxt   = phase_r;
    fire_ch_nxt = fire_ch_r;
    start_nxt   = start_r;
    retry_nxt   = retry_r;
    backup_nxt  = backup_r;
    pin_nxt     = pin_r;
    cont_nxt    = cont_r;
    fired_nxt   = fired_r;
    deploy_nxt  = deploy_r;
    last_nxt    = last_r;
    status_nxt  = ST_OK;
    cont_here   = 1'b0;
    case (action_t'(act_r))
      ACT_POLL: begin
        if (since_sample >= {16'd0, period_r}) begin
          last_nxt = now_r;
          if (adc_ok_r) begin
            pin_nxt  = pin_calc;
            cont_nxt = pin_calc > thresh_r;
          end
        end
        cont_here = (fire_ch_r == 3'd0) && cont_nxt;
        case (phase_r)
          PH_FIRING: begin
            if (aborting) begin
              phase_nxt  = PH_IDLE;
              backup_nxt = 1'b0;
            end else if (since_phase >= {16'd0, pulse_r}) begin
              start_nxt = now_r;
              phase_nxt = PH_SETTLE;
            end
          end
          PH_SETTLE: begin
            if (since_phase >= {16'd0, settle_r}) begin
              if (cont_here && retry_r < retry_lim_r && !aborting) begin
                retry_nxt = retry_r + 4'd1;
                start_nxt = now_r;
                phase_nxt = PH_FIRING;
              end else begin
                if (cont_here) begin
                  deploy_nxt = 1'b1;
                end
                phase_nxt  = PH_IDLE;
                backup_nxt = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      ACT_FIRE, ACT_BACKUP: begin
        if ({1'b0, ch_r} >= NumChW) begin
          status_nxt = ST_BAD_CHANNEL;
        end else if (act_r == ACT_FIRE && !may_fire) begin
          status_nxt = ST_NOT_ALLOWED;
        end else if (phase_r != PH_IDLE) begin
          status_nxt = ST_BUSY;
        end else begin
          fire_ch_nxt = ch_r;
          retry_nxt   = 4'd0;
          backup_nxt  = (act_r == ACT_BACKUP);
          fired_nxt   = fired_r | ch_onehot[NUM_CH-1:0];
          start_nxt   = now_r;
          phase_nxt   = PH_FIRING;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r     <= RST_CONT_THRESH;
      pulse_r      <= RST_PULSE;
      settle_r     <= RST_SETTLE;
      period_r     <= RST_SAMPLE_PERIOD;
      retry_lim_r  <= RST_RETRY_LIMIT;
      div_r        <= RST_DIVIDER;
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      phase_r      <= PH_IDLE;
      fire_ch_r    <= 3'd0;
      start_r      <= 32'd0;
      retry_r      <= 4'd0;
      backup_r     <= 1'b0;
      pin_r        <= 12'd0;
      cont_r       <= 1'b0;
      fired_r      <= '0;
      deploy_r     <= 1'b0;
      last_r       <= 32'd0;
      act_r        <= ACT_POLL;
      now_r        <= 32'd0;
      ch_r         <= 3'd0;
      prod_r       <= 24'd0;
      adc_ok_r     <= 1'b0;
      armed_r      <= 1'b0;
      gidle_r      <= 1'b0;
      init_r       <= 1'b0;
      test_r       <= 1'b0;
      out_status_r <= ST_OK;
      out_ch_r     <= 3'd0;
      out_phase_r  <= PH_IDLE;
      out_cont_r   <= 1'b0;
      out_fired_r  <= 8'd0;
      out_deploy_r <= 1'b0;
      out_pin_r    <= 12'd0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(cfg_idx))
          REG_CONT_THRESH:   thresh_r    <= cfg_pwdata[11:0];
          REG_PULSE:         pulse_r     <= cfg_pwdata[15:0];
          REG_SETTLE:        settle_r    <= cfg_pwdata[15:0];
          REG_SAMPLE_PERIOD: period_r    <= cfg_pwdata[15:0];
          REG_RETRY_LIMIT:   retry_lim_r <= cfg_pwdata[3:0];
          REG_DIVIDER:       div_r       <= cfg_pwdata[3:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        in_vld_r <= 1'b1;
        act_r    <= in_tuser;
        now_r    <= in_tdata[31:0];
        ch_r     <= in_tdata[34:32];
        prod_r   <= prod_in;
        adc_ok_r <= in_tdata[47];
        armed_r  <= in_tdata[48];
        gidle_r  <= in_tdata[49];
        init_r   <= in_tdata[50];
        test_r   <= in_tdata[51];
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r    <= 1'b1;
        phase_r      <= phase_nxt;
        fire_ch_r    <= fire_ch_nxt;
        start_r      <= start_nxt;
        retry_r      <= retry_nxt;
        backup_r     <= backup_nxt;
        pin_r        <= pin_nxt;
        cont_r       <= cont_nxt;
        fired_r      <= fired_nxt;
        deploy_r     <= deploy_nxt;
        last_r       <= last_nxt;
        out_status_r <= status_nxt;
        out_ch_r     <= fire_ch_nxt;
        out_phase_r  <= phase_nxt;
        out_cont_r   <= cont_nxt;
        out_fired_r  <= 8'(fired_nxt);
        out_deploy_r <= deploy_nxt;
        out_pin_r    <= pin_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // the user must change divider only while idle so out pin value scales; not enforced
  assign battery    = 16'(out_pin_r) * 16'(div_r);
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'd0, battery, out_pin_r, out_deploy_r, out_fired_r,
                       7'd0, out_cont_r, out_phase_r, out_ch_r,
                       (out_phase_r == PH_FIRING)};

  `PFRS_ASSERT_NOW(a_idle_no_backup, clk, rst_n, phase_r == PH_IDLE, !backup_r, "backup set while idle")
  `PFRS_ASSERT_NEXT(a_hold_input, clk, rst_n, in_vld_r && !adv, in_vld_r, "pending input word lost")
  `PFRS_ASSERT_NEXT(a_result_loaded, clk, rst_n, adv, out_vld_r, "result not registered")
  `PFRS_ASSERT_NOW(a_deploy_from_settle, clk, rst_n, $rose(deploy_r), $past(phase_r) == PH_SETTLE, "deploy fail outside settle")
  `PFRS_ASSERT_NEXT(a_state_frozen, clk, rst_n, !adv, $stable(phase_r) && $stable(retry_r), "state moved without a word")

endmodule

`default_nettype wire
